/* sv/sdsl_pkg.sv */
// Shared constants and types for the symmetric double-step line rasterizer.
package sdsl_pkg;

  // Default coordinate width of the line endpoints and pixels.
  localparam int COORD_BITS_DEF = 12;

  // Input word kinds.
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_STEP  = 1'b1;

  // Largest number of pixels one input word produces.
  localparam int MAX_PIX = 4;

  // Summary of what the rasterizer core produced for one input word.
  typedef struct packed {
    logic [2:0] cnt;   // number of valid pixels, 0 to 4
    logic       done;  // the last of those pixels ends the line
  } core_res_t;

endpackage

/* sv/symmetric_double_step_line.sv */
// Top level of the symmetric double-step line rasterizer with its stream ports.
//
//   Channel  Dir  Handshake         Contents
//   s_*      in   tvalid / tready   tuser: kind; tdata: endpoint coordinates
//   m_*      out  tvalid / tready   tdata: pixel x,y; tlast: last_of_run; tuser: line_done
//
// One input word is registered, then expanded into up to four pixels held in a
// small buffer; pixels leave through an output register, one per cycle while the
// result side is ready. A step word gives up to four pixels, a start word one or
// two, and a step with no active line none; the result port sets the pace.
// Reset clears all valid flags and the line state. Stalls on the result side fill
// the output register, then the buffer, then the input register, and hold them.
module symmetric_double_step_line #(
  parameter int COORD_BITS = sdsl_pkg::COORD_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // tdata from bit 0 up: x_start, y_start, x_end, y_end, zero fill.
  input  logic [((4*COORD_BITS+7)/8)*8-1:0] s_tdata,
  // tuser: kind.
  input  logic s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // tdata from bit 0 up: pixel_x, pixel_y, zero fill.
  output logic [((2*COORD_BITS+7)/8)*8-1:0] m_tdata,
  output logic m_tlast,
  // tuser: line_done.
  output logic m_tuser
);
  import sdsl_pkg::*;

  localparam int CB    = COORD_BITS;
  localparam int OUT_W = ((2*COORD_BITS+7)/8)*8;

  // Input register.
  logic          in_vld, in_kind;
  logic [CB-1:0] in_xs, in_ys, in_xe, in_ye;

  // Pixel buffer, shifted toward slot 0 as pixels leave.
  logic [CB-1:0] buf_x [MAX_PIX];
  logic [CB-1:0] buf_y [MAX_PIX];
  logic          buf_last [MAX_PIX];
  logic          buf_done [MAX_PIX];
  logic [2:0]    buf_cnt;

  // Output register.
  logic          out_vld, out_last, out_done;
  logic [CB-1:0] out_x, out_y;

  logic [CB-1:0] pix_x [MAX_PIX];
  logic [CB-1:0] pix_y [MAX_PIX];
  core_res_t     res;
  logic          pop, buf_free, load;

  // Flow control between the three register levels.
  assign pop      = (buf_cnt != 3'd0) && (!out_vld || m_tready);
  assign buf_free = (buf_cnt == 3'd0) || ((buf_cnt == 3'd1) && pop);
  assign load     = in_vld && buf_free;
  assign s_tready = !in_vld || load;

  sdsl_core #(
    .COORD_BITS (COORD_BITS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .apply   (load),
    .kind    (in_kind),
    .x_start (in_xs),
    .y_start (in_ys),
    .x_end   (in_xe),
    .y_end   (in_ye),
    .pix_x   (pix_x),
    .pix_y   (pix_y),
    .res     (res)
  );

  // Input word capture.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (load) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_kind <= s_tuser;
      in_xs   <= s_tdata[CB-1:0];
      in_ys   <= s_tdata[2*CB-1:CB];
      in_xe   <= s_tdata[3*CB-1:2*CB];
      in_ye   <= s_tdata[4*CB-1:3*CB];
    end
  end

  // Buffer count.
  always_ff @(posedge clk) begin
    if (rst) begin
      buf_cnt <= 3'd0;
    end else if (load) begin
      buf_cnt <= res.cnt;
    end else if (pop) begin
      buf_cnt <= buf_cnt - 1'b1;
    end
  end

  // Buffer contents: load a fresh set of pixels or shift one out.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int i = 0; i < MAX_PIX; i++) begin
        buf_x[i]    <= pix_x[i];
        buf_y[i]    <= pix_y[i];
        buf_last[i] <= ((3'(i) + 3'd1) == res.cnt);
        buf_done[i] <= ((3'(i) + 3'd1) == res.cnt) && res.done;
      end
    end else if (pop) begin
      for (int i = 0; i < MAX_PIX - 1; i++) begin
        buf_x[i]    <= buf_x[i+1];
        buf_y[i]    <= buf_y[i+1];
        buf_last[i] <= buf_last[i+1];
        buf_done[i] <= buf_done[i+1];
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (pop) begin
      out_vld <= 1'b1;
    end else if (m_tready) begin
      out_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_x    <= buf_x[0];
      out_y    <= buf_y[0];
      out_last <= buf_last[0];
      out_done <= buf_done[0];
    end
  end

  assign m_tvalid = out_vld;
  assign m_tdata  = OUT_W'({out_y, out_x});
  assign m_tlast  = out_last;
  assign m_tuser  = out_done;

endmodule

/* sv/sdsl_core.sv */
// Line state and single-pass pixel computation for one start or step word.
module sdsl_core #(
  parameter int COORD_BITS = sdsl_pkg::COORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  apply,
  input  logic                  kind,
  input  logic [COORD_BITS-1:0] x_start,
  input  logic [COORD_BITS-1:0] y_start,
  input  logic [COORD_BITS-1:0] x_end,
  input  logic [COORD_BITS-1:0] y_end,
  output logic [COORD_BITS-1:0] pix_x [sdsl_pkg::MAX_PIX],
  output logic [COORD_BITS-1:0] pix_y [sdsl_pkg::MAX_PIX],
  output sdsl_pkg::core_res_t   res
);
  import sdsl_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 4;
  localparam int SW = COORD_BITS - 2;

  typedef enum logic [1:0] {PAT1, PAT2, PAT3, PAT4} pattern_t;

  // Line state.
  logic [CB-1:0]        near_major, near_minor, far_major, far_minor;
  logic signed [DW-1:0] decision, pattern_incr, diag_incr, threshold;
  logic                 minor_down, axes_swapped, shallow_slope, line_active;
  logic [SW-1:0]        steps_remaining;
  logic [1:0]           leftover_pixels;

  logic [CB-1:0]        near_major_next, near_minor_next, far_major_next, far_minor_next;
  logic signed [DW-1:0] decision_next, pattern_incr_next, diag_incr_next, threshold_next;
  logic                 minor_down_next, axes_swapped_next, shallow_slope_next;
  logic                 line_active_next;
  logic [SW-1:0]        steps_remaining_next;
  logic [1:0]           leftover_pixels_next;

  // Start setup terms.
  logic signed [CB:0]   ddx, ddy;
  logic [CB-1:0]        adx, ady, dx, dy, dx_m1;
  logic [CB-1:0]        ma1, mi1, ma2, mi2;
  logic                 swap_new;
  logic signed [DW-1:0] dx_s, dy_s, diag_s, thr_s, pat_s;

  // Step terms.
  pattern_t             pat;
  logic                 adv_first, adv_second, far_move;
  logic [CB-1:0]        nm1, nm2, nn1, nn2, fm1, fm2, fn1, fn2, fn_left;
  logic [CB-1:0]        maj [MAX_PIX];
  logic [CB-1:0]        mnr [MAX_PIX];
  logic                 swap_out;

  function automatic logic [COORD_BITS-1:0] minor_fwd(input logic [COORD_BITS-1:0] v,
                                                      input logic down);
    minor_fwd = down ? v - 1'b1 : v + 1'b1;
  endfunction

  function automatic logic [COORD_BITS-1:0] minor_back(input logic [COORD_BITS-1:0] v,
                                                       input logic down);
    minor_back = down ? v + 1'b1 : v - 1'b1;
  endfunction

  // Endpoint setup: spans, axis swap, major/minor selection and decision terms.
  always_comb begin
    ddx      = $signed({1'b0, x_end}) - $signed({1'b0, x_start});
    ddy      = $signed({1'b0, y_end}) - $signed({1'b0, y_start});
    adx      = ddx[CB] ? CB'(-ddx) : ddx[CB-1:0];
    ady      = ddy[CB] ? CB'(-ddy) : ddy[CB-1:0];
    swap_new = ady > adx;
    if (swap_new) begin
      ma1 = y_start; mi1 = x_start; ma2 = y_end; mi2 = x_end; dx = ady; dy = adx;
    end else begin
      ma1 = x_start; mi1 = y_start; ma2 = x_end; mi2 = y_end; dx = adx; dy = ady;
    end
    dx_m1  = dx - 1'b1;
    dx_s   = $signed(DW'(dx));
    dy_s   = $signed(DW'(dy));
    diag_s = (dy_s <<< 2) - (dx_s <<< 1);
    thr_s  = diag_s[DW-1] ? (dy_s <<< 1) : ((dy_s - dx_s) <<< 1);
    pat_s  = thr_s <<< 1;
  end

  // Pattern choice and the walk of both ends.
  always_comb begin
    if (shallow_slope) begin
      if (decision < 0)              pat = PAT1;
      else if (decision < threshold) pat = PAT2;
      else                           pat = PAT3;
    end else begin
      if (decision > 0)              pat = PAT4;
      else if (decision < threshold) pat = PAT2;
      else                           pat = PAT3;
    end
    adv_first  = (pat == PAT3) || (pat == PAT4);
    adv_second = (pat == PAT2) || (pat == PAT4);
    if (shallow_slope) far_move = (pat == PAT3);
    else far_move = (pat == PAT4) || ((pat == PAT3) && (decision > threshold));

    nm1     = near_major + 1'b1;
    nm2     = nm1 + 1'b1;
    nn1     = adv_first ? minor_fwd(near_minor, minor_down) : near_minor;
    nn2     = adv_second ? minor_fwd(nn1, minor_down) : nn1;
    fm1     = far_major - 1'b1;
    fm2     = fm1 - 1'b1;
    fn1     = adv_first ? minor_back(far_minor, minor_down) : far_minor;
    fn2     = adv_second ? minor_back(fn1, minor_down) : fn1;
    fn_left = far_move ? minor_back(far_minor, minor_down) : far_minor;
  end

  // Next state and pixel list for the word at the input.
  always_comb begin
    near_major_next      = near_major;
    near_minor_next      = near_minor;
    far_major_next       = far_major;
    far_minor_next       = far_minor;
    decision_next        = decision;
    pattern_incr_next    = pattern_incr;
    diag_incr_next       = diag_incr;
    threshold_next       = threshold;
    minor_down_next      = minor_down;
    axes_swapped_next    = axes_swapped;
    shallow_slope_next   = shallow_slope;
    line_active_next     = line_active;
    steps_remaining_next = steps_remaining;
    leftover_pixels_next = leftover_pixels;
    res.cnt              = 3'd0;
    res.done             = 1'b0;
    for (int i = 0; i < MAX_PIX; i++) begin
      maj[i] = nm1;
      mnr[i] = nn1;
    end
    swap_out = axes_swapped;

    unique case (kind)
      KIND_START: begin
        minor_down_next   = ddx[CB] ^ ddy[CB];
        axes_swapped_next = swap_new;
        swap_out          = swap_new;
        if (ma1 > ma2) begin
          near_major_next = ma2; near_minor_next = mi2;
          far_major_next  = ma1; far_minor_next  = mi1;
        end else begin
          near_major_next = ma1; near_minor_next = mi1;
          far_major_next  = ma2; far_minor_next  = mi2;
        end
        maj[0] = near_major_next; mnr[0] = near_minor_next;
        maj[1] = far_major_next;  mnr[1] = far_minor_next;
        if (dx == '0) begin
          // Zero length: a single pixel ends the line.
          line_active_next     = 1'b0;
          steps_remaining_next = '0;
          leftover_pixels_next = 2'd0;
          res.cnt              = 3'd1;
          res.done             = 1'b1;
        end else begin
          steps_remaining_next = dx_m1[CB-1:2];
          leftover_pixels_next = dx_m1[1:0];
          diag_incr_next       = diag_s;
          shallow_slope_next   = diag_s[DW-1];
          threshold_next       = thr_s;
          pattern_incr_next    = pat_s;
          decision_next        = diag_s[DW-1] ? pat_s - dx_s : pat_s + dx_s;
          line_active_next     = (dx_m1 != '0);
          res.cnt              = 3'd2;
          res.done             = (dx_m1 == '0);
        end
      end
      KIND_STEP: begin
        if (line_active) begin
          if (steps_remaining != '0) begin
            // Full double step: two pixels from each end.
            maj[0] = nm1; mnr[0] = nn1;
            maj[1] = nm2; mnr[1] = nn2;
            maj[2] = fm1; mnr[2] = fn1;
            maj[3] = fm2; mnr[3] = fn2;
            near_major_next      = nm2;
            near_minor_next      = nn2;
            far_major_next       = fm2;
            far_minor_next       = fn2;
            decision_next        = decision +
                                   (((pat == PAT1) || (pat == PAT4)) ? pattern_incr : diag_incr);
            steps_remaining_next = steps_remaining - 1'b1;
            res.cnt              = 3'd4;
            if ((steps_remaining == SW'(1)) && (leftover_pixels == 2'd0)) begin
              line_active_next = 1'b0;
              res.done         = 1'b1;
            end
          end else begin
            // Final step: the leftover pixels.
            maj[0] = nm1; mnr[0] = nn1;
            maj[1] = nm2; mnr[1] = nn2;
            maj[2] = fm1; mnr[2] = fn_left;
            near_major_next  = (leftover_pixels > 2'd1) ? nm2 : nm1;
            near_minor_next  = (leftover_pixels > 2'd1) ? nn2 : nn1;
            line_active_next = 1'b0;
            res.cnt          = {1'b0, leftover_pixels};
            res.done         = 1'b1;
          end
        end
      end
      default: begin
        res.cnt = 3'd0;
      end
    endcase

    // Back to x,y order for steep lines.
    for (int i = 0; i < MAX_PIX; i++) begin
      pix_x[i] = swap_out ? mnr[i] : maj[i];
      pix_y[i] = swap_out ? maj[i] : mnr[i];
    end
  end

  // State registers, updated once per word taken by the buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active     <= 1'b0;
      steps_remaining <= '0;
      leftover_pixels <= 2'd0;
      near_major      <= '0;
      near_minor      <= '0;
      far_major       <= '0;
      far_minor       <= '0;
      decision        <= '0;
      pattern_incr    <= '0;
      diag_incr       <= '0;
      threshold       <= '0;
      minor_down      <= 1'b0;
      axes_swapped    <= 1'b0;
      shallow_slope   <= 1'b0;
    end else if (apply) begin
      line_active     <= line_active_next;
      steps_remaining <= steps_remaining_next;
      leftover_pixels <= leftover_pixels_next;
      near_major      <= near_major_next;
      near_minor      <= near_minor_next;
      far_major       <= far_major_next;
      far_minor       <= far_minor_next;
      decision        <= decision_next;
      pattern_incr    <= pattern_incr_next;
      diag_incr       <= diag_incr_next;
      threshold       <= threshold_next;
      minor_down      <= minor_down_next;
      axes_swapped    <= axes_swapped_next;
      shallow_slope   <= shallow_slope_next;
    end
  end

endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the symmetric double-step line rasterizer.
`timescale 1ns / 1ps

module tb_top;
  import sdsl_pkg::*;

  localparam int CW = COORD_BITS_DEF;
  localparam int SW = ((4 * CW + 7) / 8) * 8;
  localparam int MW = ((2 * CW + 7) / 8) * 8;
  localparam int CMAX = (1 << CW) - 1;

  // Step patterns: S is a straight move, D a diagonal move of the minor axis.
  localparam int PAT_SS = 1;
  localparam int PAT_SD = 2;
  localparam int PAT_DS = 3;
  localparam int PAT_DD = 4;

  // A directed row with this count is checked against the predictor.
  localparam int NO_TYPED = -1;
  localparam int RAND_WORDS = 290;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 20;

  typedef logic [CW-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic   last;
    logic   done;
  } pixel_t;

  typedef struct packed {
    logic   kind;
    coord_t xs;
    coord_t ys;
    coord_t xe;
    coord_t ye;
    int     typed_n;
    pixel_t t0;
    pixel_t t1;
  } row_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [SW-1:0] s_tdata = '0;
  logic          s_tuser = 1'b0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [MW-1:0] m_tdata;
  logic          m_tlast;
  logic          m_tuser;

  symmetric_double_step_line #(.COORD_BITS(CW)) u_top (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tlast (m_tlast),
    .m_tuser (m_tuser)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Rasterizer state as predicted by the testbench.
  coord_t near_mj = '0, near_mn = '0, far_mj = '0, far_mn = '0;
  int     dvar = 0, dvar_step = 0, dvar_diag = 0, dvar_limit = 0;
  logic   walk_down = 1'b0, steep = 1'b0, flat = 1'b0, drawing = 1'b0;
  int     double_steps = 0, tail_pixels = 0;

  pixel_t word_pixels[$];
  pixel_t pixels_due[$];
  int     errors = 0;
  int     busy_words = 0;
  int     idle_pct = 0;
  int     stall_pct = 0;
  logic   hold_go = 1'b0;
  logic   hold_used = 1'b0;
  int     hold_left = 0;
  row_t   plan[$];
  pixel_t got_pix, want_pix;

  function automatic pixel_t pix(input coord_t x, y, input logic last, done);
    pixel_t p;
    p.x = x;
    p.y = y;
    p.last = last;
    p.done = done;
    return p;
  endfunction

  function automatic row_t row(input logic kind, input coord_t xs, ys, xe, ye,
                               input int typed_n, input pixel_t t0, t1);
    row_t r;
    r.kind = kind;
    r.xs = xs;
    r.ys = ys;
    r.xe = xe;
    r.ye = ye;
    r.typed_n = typed_n;
    r.t0 = t0;
    r.t1 = t1;
    return r;
  endfunction

  function automatic coord_t minor_ahead(input coord_t v);
    return walk_down ? v - 1'b1 : v + 1'b1;
  endfunction

  function automatic coord_t minor_back(input coord_t v);
    return walk_down ? v + 1'b1 : v - 1'b1;
  endfunction

  // Queue one pixel of the current word, swapping back to x,y for steep lines.
  function automatic void add_pix(input coord_t mj, mn);
    word_pixels.push_back(pix(steep ? mn : mj, steep ? mj : mn, 1'b0, 1'b0));
  endfunction

  function automatic int pick_pattern();
    if (flat)
      return dvar < 0 ? PAT_SS : (dvar < dvar_limit ? PAT_SD : PAT_DS);
    return dvar > 0 ? PAT_DD : (dvar < dvar_limit ? PAT_SD : PAT_DS);
  endfunction

  // Work out the pixels one input word produces and advance the line state.
  function automatic void rasterize(input logic kind, input coord_t xs, ys, xe, ye);
    int     ixs, iys, ixe, iye, ddx, ddy, adx, ady, dx, dy, p;
    coord_t ma1, mi1, ma2, mi2;
    logic   finished, first_diag, second_diag, move;
    pixel_t tail;
    word_pixels.delete();
    finished = 1'b0;
    if (kind == KIND_START) begin
      ixs = xs;
      iys = ys;
      ixe = xe;
      iye = ye;
      ddx = ixe - ixs;
      ddy = iye - iys;
      adx = ddx < 0 ? -ddx : ddx;
      ady = ddy < 0 ? -ddy : ddy;
      walk_down = (ddx < 0) != (ddy < 0);
      steep = ady > adx;
      if (steep) begin
        ma1 = ys; mi1 = xs; ma2 = ye; mi2 = xe; dx = ady; dy = adx;
      end else begin
        ma1 = xs; mi1 = ys; ma2 = xe; mi2 = ye; dx = adx; dy = ady;
      end
      if (ma1 > ma2) begin
        near_mj = ma2; near_mn = mi2; far_mj = ma1; far_mn = mi1;
      end else begin
        near_mj = ma1; near_mn = mi1; far_mj = ma2; far_mn = mi2;
      end
      add_pix(near_mj, near_mn);
      if (dx == 0) begin
        drawing = 1'b0;
        double_steps = 0;
        tail_pixels = 0;
        finished = 1'b1;
      end else begin
        add_pix(far_mj, far_mn);
        double_steps = (dx - 1) / 4;
        tail_pixels = (dx - 1) % 4;
        dvar_diag = 4 * dy - 2 * dx;
        flat = dvar_diag < 0;
        if (flat) begin
          dvar_limit = 2 * dy;
          dvar_step = 2 * dvar_limit;
          dvar = dvar_step - dx;
        end else begin
          dvar_limit = 2 * (dy - dx);
          dvar_step = 2 * dvar_limit;
          dvar = dvar_step + dx;
        end
        drawing = !(double_steps == 0 && tail_pixels == 0);
        finished = !drawing;
      end
    end else if (drawing) begin
      p = pick_pattern();
      first_diag = (p == PAT_DS || p == PAT_DD);
      second_diag = (p == PAT_SD || p == PAT_DD);
      if (double_steps > 0) begin
        // Two pixels from each end.
        near_mj = near_mj + 1'b1;
        far_mj = far_mj - 1'b1;
        if (first_diag) near_mn = minor_ahead(near_mn);
        add_pix(near_mj, near_mn);
        near_mj = near_mj + 1'b1;
        if (second_diag) near_mn = minor_ahead(near_mn);
        add_pix(near_mj, near_mn);
        if (first_diag) far_mn = minor_back(far_mn);
        add_pix(far_mj, far_mn);
        far_mj = far_mj - 1'b1;
        if (second_diag) far_mn = minor_back(far_mn);
        add_pix(far_mj, far_mn);
        dvar += (p == PAT_SS || p == PAT_DD) ? dvar_step : dvar_diag;
        double_steps--;
        if (double_steps == 0 && tail_pixels == 0) begin
          drawing = 1'b0;
          finished = 1'b1;
        end
      end else begin
        // Final step: the leftover pixels in the middle of the line.
        near_mj = near_mj + 1'b1;
        if (first_diag) near_mn = minor_ahead(near_mn);
        add_pix(near_mj, near_mn);
        if (tail_pixels > 1) begin
          near_mj = near_mj + 1'b1;
          if (second_diag) near_mn = minor_ahead(near_mn);
          add_pix(near_mj, near_mn);
        end
        if (tail_pixels > 2) begin
          far_mj = far_mj - 1'b1;
          move = flat ? (p == PAT_DS) : (p == PAT_DD || (p == PAT_DS && dvar > dvar_limit));
          if (move) far_mn = minor_back(far_mn);
          add_pix(far_mj, far_mn);
        end
        drawing = 1'b0;
        finished = 1'b1;
      end
    end
    if (word_pixels.size() > 0) begin
      tail = word_pixels.pop_back();
      tail.last = 1'b1;
      tail.done = finished;
      word_pixels.push_back(tail);
    end
  endfunction

  // Offer one word, wait for it to be taken, then queue its expected pixels.
  task automatic send_word(input logic kind, input coord_t xs, ys, xe, ye,
                           input int typed_n, input pixel_t t0, t1);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= kind;
    s_tdata <= {ye, xe, ys, xs};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    rasterize(kind, xs, ys, xe, ye);
    if (word_pixels.size() > 0) busy_words++;
    if (typed_n == NO_TYPED) begin
      foreach (word_pixels[i]) pixels_due.push_back(word_pixels[i]);
    end else begin
      if (typed_n > 0) pixels_due.push_back(t0);
      if (typed_n > 1) pixels_due.push_back(t1);
    end
  endtask

  // Pick an end coordinate a short distance from c, staying in range.
  function automatic coord_t near_coord(input coord_t c, input int span);
    int d, t;
    d = $urandom_range(0, 2 * span) - span;
    t = int'(c) + d;
    if (t < 0 || t > CMAX) t = int'(c) - d;
    return t[CW-1:0];
  endfunction

  // Result side: random stalls, plus one long hold-off that backs up the input.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_used) begin
      m_tready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Compare each pixel word taken from the block with the oldest expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      got_pix = pix(m_tdata[CW-1:0], m_tdata[2*CW-1:CW], m_tlast, m_tuser);
      if (pixels_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel x=%0d y=%0d last=%0b done=%0b", $time,
                 got_pix.x, got_pix.y, got_pix.last, got_pix.done);
      end else begin
        want_pix = pixels_due.pop_front();
        if (got_pix.x !== want_pix.x || got_pix.y !== want_pix.y ||
            got_pix.last !== want_pix.last || got_pix.done !== want_pix.done) begin
          errors++;
          $display({"%0t: pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                    " got x=%0d y=%0d last=%0b done=%0b"},
                   $time, want_pix.x, want_pix.y, want_pix.last, want_pix.done,
                   got_pix.x, got_pix.y, got_pix.last, got_pix.done);
        end
      end
    end
  end

  // Stimulus: directed rows, then random lines in four phases of input idling and output stalls.
  initial begin
    int     mode, need, n_steps, r, phase, drain;
    coord_t xs, ys, xe, ye;

    // Step with no line, single points, unit spans, extremes, both slope cases.
    plan.push_back(row(KIND_STEP, 0, 0, 0, 0, 0, '0, '0));
    plan.push_back(row(KIND_START, 0, 0, 0, 0, 1, pix(0, 0, 1, 1), '0));
    plan.push_back(row(KIND_START, CMAX, CMAX, CMAX, CMAX, 1,
                       pix(CMAX, CMAX, 1, 1), '0));
    plan.push_back(row(KIND_START, 10, 20, 11, 20, 2,
                       pix(10, 20, 0, 0), pix(11, 20, 1, 1)));
    plan.push_back(row(KIND_STEP, CMAX, CMAX, CMAX, CMAX, 0, '0, '0));
    plan.push_back(row(KIND_START, 0, 0, CMAX, CMAX, 2,
                       pix(0, 0, 0, 0), pix(CMAX, CMAX, 1, 0)));
    plan.push_back(row(KIND_STEP, 0, 0, 0, 0, NO_TYPED, '0, '0));
    plan.push_back(row(KIND_STEP, 0, 0, 0, 0, NO_TYPED, '0, '0));
    // A new start drops the line still in progress.
    plan.push_back(row(KIND_START, CMAX, 0, 0, CMAX, 2,
                       pix(0, CMAX, 0, 0), pix(CMAX, 0, 1, 0)));
    plan.push_back(row(KIND_STEP, 0, 0, 0, 0, NO_TYPED, '0, '0));
    plan.push_back(row(KIND_START, CMAX, CMAX, CMAX - 5, 0, NO_TYPED, '0, '0));
    plan.push_back(row(KIND_STEP, 0, 0, 0, 0, NO_TYPED, '0, '0));
    // Steep line ending on a single leftover pixel.
    plan.push_back(row(KIND_START, 100, 100, 103, 110, NO_TYPED, '0, '0));
    repeat (3) plan.push_back(row(KIND_STEP, 0, 0, 0, 0, NO_TYPED, '0, '0));
    // Shallow line with no leftover: the last double step ends it.
    plan.push_back(row(KIND_START, 0, 0, 13, 2, NO_TYPED, '0, '0));
    repeat (3) plan.push_back(row(KIND_STEP, 0, 0, 0, 0, NO_TYPED, '0, '0));
    // Steep, falling minor axis, three leftover pixels.
    plan.push_back(row(KIND_START, 50, 60, 53, 52, NO_TYPED, '0, '0));
    repeat (2) plan.push_back(row(KIND_STEP, 0, 0, 0, 0, NO_TYPED, '0, '0));
    plan.push_back(row(KIND_STEP, 0, 0, 0, 0, 0, '0, '0));

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i])
      send_word(plan[i].kind, plan[i].xs, plan[i].ys, plan[i].xe, plan[i].ye,
                plan[i].typed_n, plan[i].t0, plan[i].t1);

    busy_words = 0;
    while (busy_words < RAND_WORDS) begin
      phase = busy_words * 4 / RAND_WORDS;
      case (phase)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
          if (busy_words >= 20) hold_go = 1'b1;
        end
        1: begin
          idle_pct = 59;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 59;
        end
        default: begin
          idle_pct = 16;
          stall_pct = 16;
        end
      endcase

      // Mostly short lines that run to completion, some long or degenerate.
      xs = $urandom_range(0, CMAX);
      ys = $urandom_range(0, CMAX);
      mode = $urandom_range(0, 15);
      if (mode == 0) begin
        xe = $urandom_range(0, CMAX);
        ye = $urandom_range(0, CMAX);
      end else if (mode == 1) begin
        xe = xs;
        ye = near_coord(ys, 2);
      end else if (mode == 2) begin
        xe = near_coord(xs, 40);
        ye = ys;
      end else if (mode == 3) begin
        xe = near_coord(xs, 2);
        ye = near_coord(ys, 40);
      end else begin
        xe = near_coord(xs, 40);
        ye = near_coord(ys, 40);
      end
      send_word(KIND_START, xs, ys, xe, ye, NO_TYPED, '0, '0);

      need = drawing ? double_steps + (tail_pixels != 0) : 0;
      r = $urandom_range(0, 9);
      if (r == 0)
        n_steps = $urandom_range(0, need);
      else if (r == 1)
        n_steps = need + $urandom_range(1, 2);
      else
        n_steps = need;
      if (n_steps > 12) n_steps = $urandom_range(1, 12);

      // Step words carry random data that the block must ignore.
      repeat (n_steps)
        send_word(KIND_STEP, $urandom, $urandom, $urandom, $urandom, NO_TYPED, '0, '0);
    end
    s_tvalid <= 1'b0;

    drain = 0;
    while (pixels_due.size() > 0 && drain < DRAIN_LIMIT) begin
      @(posedge clk);
      drain++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pixels_due.size() != 0) begin
      errors++;
      $display("%0t: %0d expected pixels never arrived, next x=%0d y=%0d", $time,
               pixels_due.size(), pixels_due[0].x, pixels_due[0].y);
    end

    if (errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  // Hard stop in case the block hangs.
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
